// ===== rtl/rv32im_instruction_decoder_core_defines.svh =====
// Assertion macros for the RV32IM instruction decoder.
`ifndef RV32IM_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define RV32IM_INSTRUCTION_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define RVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVD_ASSERT(lbl, prop, msg)
`define RVD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/rv32dec_pkg.sv =====
// Package: codes, types and field widths of the RV32IM instruction decoder.
package rv32dec_pkg;

  localparam int XLEN = 32;

  typedef logic [5:0]      kind_t;
  typedef logic [2:0]      fmt_t;
  typedef logic [4:0]      alu_t;
  typedef logic [6:0]      flags_t;
  typedef logic [4:0]      reg_idx_t;
  typedef logic [XLEN-1:0] word_t;

  // opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_B    = 3'd0;
  localparam logic [2:0] F3_H    = 3'd1;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_HU   = 3'd5;

  localparam logic [6:0]  F7_MULDIV   = 7'h01;
  localparam logic [11:0] SYS_ECALL   = 12'h000;
  localparam logic [11:0] SYS_EBREAK  = 12'h001;

  // instruction kinds
  localparam kind_t K_UNKNOWN = 6'd0;
  localparam kind_t K_LUI     = 6'd1;
  localparam kind_t K_AUIPC   = 6'd2;
  localparam kind_t K_JAL     = 6'd3;
  localparam kind_t K_JALR    = 6'd4;
  localparam kind_t K_BEQ     = 6'd5;
  localparam kind_t K_BNE     = 6'd6;
  localparam kind_t K_BLT     = 6'd7;
  localparam kind_t K_BGE     = 6'd8;
  localparam kind_t K_BLTU    = 6'd9;
  localparam kind_t K_BGEU    = 6'd10;
  localparam kind_t K_LB      = 6'd11;
  localparam kind_t K_LH      = 6'd12;
  localparam kind_t K_LW      = 6'd13;
  localparam kind_t K_LBU     = 6'd14;
  localparam kind_t K_LHU     = 6'd15;
  localparam kind_t K_SB      = 6'd16;
  localparam kind_t K_SH      = 6'd17;
  localparam kind_t K_SW      = 6'd18;
  localparam kind_t K_ADDI    = 6'd19;
  localparam kind_t K_SLTI    = 6'd20;
  localparam kind_t K_SLTIU   = 6'd21;
  localparam kind_t K_XORI    = 6'd22;
  localparam kind_t K_ORI     = 6'd23;
  localparam kind_t K_ANDI    = 6'd24;
  localparam kind_t K_SLLI    = 6'd25;
  localparam kind_t K_SRLI    = 6'd26;
  localparam kind_t K_SRAI    = 6'd27;
  localparam kind_t K_ADD     = 6'd28;
  localparam kind_t K_SUB     = 6'd29;
  localparam kind_t K_SLL     = 6'd30;
  localparam kind_t K_SLT     = 6'd31;
  localparam kind_t K_SLTU    = 6'd32;
  localparam kind_t K_XOR     = 6'd33;
  localparam kind_t K_SRL     = 6'd34;
  localparam kind_t K_SRA     = 6'd35;
  localparam kind_t K_OR      = 6'd36;
  localparam kind_t K_AND     = 6'd37;
  localparam kind_t K_MUL     = 6'd38;
  localparam kind_t K_ECALL   = 6'd46;
  localparam kind_t K_EBREAK  = 6'd47;

  // formats
  localparam fmt_t FMT_UNKNOWN = 3'd0;
  localparam fmt_t FMT_R       = 3'd1;
  localparam fmt_t FMT_I       = 3'd2;
  localparam fmt_t FMT_S       = 3'd3;
  localparam fmt_t FMT_B       = 3'd4;
  localparam fmt_t FMT_U       = 3'd5;
  localparam fmt_t FMT_J       = 3'd6;

  // ALU operations
  localparam alu_t ALU_ADD    = 5'd0;
  localparam alu_t ALU_SUB    = 5'd1;
  localparam alu_t ALU_AND    = 5'd2;
  localparam alu_t ALU_OR     = 5'd3;
  localparam alu_t ALU_XOR    = 5'd4;
  localparam alu_t ALU_SLL    = 5'd5;
  localparam alu_t ALU_SRL    = 5'd6;
  localparam alu_t ALU_SRA    = 5'd7;
  localparam alu_t ALU_SLT    = 5'd8;
  localparam alu_t ALU_SLTU   = 5'd9;
  localparam alu_t ALU_PASS_B = 5'd10;
  localparam alu_t ALU_MUL    = 5'd11;

  // control flag bits
  localparam int FL_REGWRITE = 0;
  localparam int FL_MEMREAD  = 1;
  localparam int FL_MEMWRITE = 2;
  localparam int FL_MEMTOREG = 3;
  localparam int FL_ALUSRC   = 4;
  localparam int FL_BRANCH   = 5;
  localparam int FL_JUMP     = 6;

  localparam flags_t FLM_REGWRITE = flags_t'(1) << FL_REGWRITE;
  localparam flags_t FLM_MEMREAD  = flags_t'(1) << FL_MEMREAD;
  localparam flags_t FLM_MEMWRITE = flags_t'(1) << FL_MEMWRITE;
  localparam flags_t FLM_MEMTOREG = flags_t'(1) << FL_MEMTOREG;
  localparam flags_t FLM_ALUSRC   = flags_t'(1) << FL_ALUSRC;
  localparam flags_t FLM_BRANCH   = flags_t'(1) << FL_BRANCH;
  localparam flags_t FLM_JUMP     = flags_t'(1) << FL_JUMP;

  // decoded control group
  typedef struct packed {
    kind_t  kind;
    fmt_t   format;
    word_t  immediate;
    alu_t   alu_operation;
    flags_t control_flags;
  } dec_t;

  // full result item
  typedef struct packed {
    dec_t     dec;
    reg_idx_t dest_reg;
    reg_idx_t src1_reg;
    reg_idx_t src2_reg;
    word_t    pc_out;
  } res_t;

endpackage

// ===== rtl/rv32dec_in_if.sv =====
// Interface: instruction input channel.
interface rv32dec_in_if;
  logic                      valid;
  logic                      ready;
  logic [31:0]               instr_word;
  logic [31:0]               fetch_pc;

  modport source (output valid, output instr_word, output fetch_pc, input ready);
  modport sink   (input valid, input instr_word, input fetch_pc, output ready);
endinterface

// ===== rtl/rv32dec_out_if.sv =====
// Interface: decoded result channel.
interface rv32dec_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         kind;
  logic [2:0]         format;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic [4:0]         alu_operation;
  logic [6:0]         control_flags;
  logic [31:0]        pc_out;

  modport source (output valid, output kind, output format, output dest_reg,
                  output src1_reg, output src2_reg, output immediate,
                  output alu_operation, output control_flags, output pc_out,
                  input ready);
  modport sink   (input valid, input kind, input format, input dest_reg,
                  input src1_reg, input src2_reg, input immediate,
                  input alu_operation, input control_flags, input pc_out,
                  output ready);
endinterface

// ===== rtl/rv32dec_in_stage.sv =====
// Input register stage: captures instruction word and fetch address.
module rv32dec_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  rv32dec_in_if.sink           in_item,
  input  logic                 dn_ready,
  output logic                 s1_valid,
  output rv32dec_pkg::word_t   s1_instr,
  output rv32dec_pkg::word_t   s1_pc
);

  logic               valid_r;
  logic               valid_nxt;
  rv32dec_pkg::word_t instr_r;
  rv32dec_pkg::word_t pc_r;
  logic               ready;

  assign ready         = !valid_r || dn_ready;
  assign in_item.ready = ready;
  assign valid_nxt     = ready ? in_item.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && ready) begin
      instr_r <= in_item.instr_word;
      pc_r    <= in_item.fetch_pc;
    end
  end

  assign s1_valid = valid_r;
  assign s1_instr = instr_r;
  assign s1_pc    = pc_r;

endmodule

// ===== rtl/rv32dec_decode.sv =====
// Combinational decode of one RV32IM instruction word.
module rv32dec_decode (
  input  rv32dec_pkg::word_t instr,
  output rv32dec_pkg::dec_t  dec
);

  logic [6:0]         opc;
  logic [2:0]         f3;
  logic [6:0]         f7;
  logic               b5;
  rv32dec_pkg::word_t imm_i;
  rv32dec_pkg::word_t imm_s;
  rv32dec_pkg::word_t imm_b;
  rv32dec_pkg::word_t imm_u;
  rv32dec_pkg::word_t imm_j;
  rv32dec_pkg::word_t shamt;

  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];
  assign b5  = instr[30];

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_u = {instr[31:12], 12'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign shamt = {27'b0, instr[24:20]};

  always_comb begin
    dec.kind          = rv32dec_pkg::K_UNKNOWN;
    dec.format        = rv32dec_pkg::FMT_UNKNOWN;
    dec.immediate     = '0;
    dec.alu_operation = rv32dec_pkg::ALU_ADD;
    dec.control_flags = '0;
    unique case (opc)
      rv32dec_pkg::OPC_LUI: begin
        dec.kind          = rv32dec_pkg::K_LUI;
        dec.format        = rv32dec_pkg::FMT_U;
        dec.immediate     = imm_u;
        dec.alu_operation = rv32dec_pkg::ALU_PASS_B;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_AUIPC: begin
        dec.kind          = rv32dec_pkg::K_AUIPC;
        dec.format        = rv32dec_pkg::FMT_U;
        dec.immediate     = imm_u;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_JAL: begin
        dec.kind          = rv32dec_pkg::K_JAL;
        dec.format        = rv32dec_pkg::FMT_J;
        dec.immediate     = imm_j;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_JUMP;
      end
      rv32dec_pkg::OPC_JALR: begin
        dec.kind          = rv32dec_pkg::K_JALR;
        dec.format        = rv32dec_pkg::FMT_I;
        dec.immediate     = imm_i;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_JUMP |
                            rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_BRANCH: begin
        dec.format        = rv32dec_pkg::FMT_B;
        dec.immediate     = imm_b;
        dec.control_flags = rv32dec_pkg::FLM_BRANCH;
        unique case (f3)
          rv32dec_pkg::F3_BEQ:  dec.kind = rv32dec_pkg::K_BEQ;
          rv32dec_pkg::F3_BNE:  dec.kind = rv32dec_pkg::K_BNE;
          rv32dec_pkg::F3_BLT:  dec.kind = rv32dec_pkg::K_BLT;
          rv32dec_pkg::F3_BGE:  dec.kind = rv32dec_pkg::K_BGE;
          rv32dec_pkg::F3_BLTU: dec.kind = rv32dec_pkg::K_BLTU;
          rv32dec_pkg::F3_BGEU: dec.kind = rv32dec_pkg::K_BGEU;
          default:              dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_LOAD: begin
        dec.format        = rv32dec_pkg::FMT_I;
        dec.immediate     = imm_i;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_MEMREAD |
                            rv32dec_pkg::FLM_MEMTOREG | rv32dec_pkg::FLM_ALUSRC;
        unique case (f3)
          rv32dec_pkg::F3_B:  dec.kind = rv32dec_pkg::K_LB;
          rv32dec_pkg::F3_H:  dec.kind = rv32dec_pkg::K_LH;
          rv32dec_pkg::F3_W:  dec.kind = rv32dec_pkg::K_LW;
          rv32dec_pkg::F3_BU: dec.kind = rv32dec_pkg::K_LBU;
          rv32dec_pkg::F3_HU: dec.kind = rv32dec_pkg::K_LHU;
          default:            dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_STORE: begin
        dec.format        = rv32dec_pkg::FMT_S;
        dec.immediate     = imm_s;
        dec.control_flags = rv32dec_pkg::FLM_MEMWRITE | rv32dec_pkg::FLM_ALUSRC;
        unique case (f3)
          rv32dec_pkg::F3_B: dec.kind = rv32dec_pkg::K_SB;
          rv32dec_pkg::F3_H: dec.kind = rv32dec_pkg::K_SH;
          rv32dec_pkg::F3_W: dec.kind = rv32dec_pkg::K_SW;
          default:           dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_IMM: begin
        dec.format        = rv32dec_pkg::FMT_I;
        dec.immediate     = imm_i;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
        unique case (f3)
          rv32dec_pkg::F3_ADD: begin
            dec.kind = rv32dec_pkg::K_ADDI;
          end
          rv32dec_pkg::F3_SLL: begin
            dec.kind          = rv32dec_pkg::K_SLLI;
            dec.alu_operation = rv32dec_pkg::ALU_SLL;
            dec.immediate     = shamt;
          end
          rv32dec_pkg::F3_SLT: begin
            dec.kind          = rv32dec_pkg::K_SLTI;
            dec.alu_operation = rv32dec_pkg::ALU_SLT;
          end
          rv32dec_pkg::F3_SLTU: begin
            dec.kind          = rv32dec_pkg::K_SLTIU;
            dec.alu_operation = rv32dec_pkg::ALU_SLTU;
          end
          rv32dec_pkg::F3_XOR: begin
            dec.kind          = rv32dec_pkg::K_XORI;
            dec.alu_operation = rv32dec_pkg::ALU_XOR;
          end
          rv32dec_pkg::F3_SR: begin
            dec.immediate     = shamt;
            dec.kind          = b5 ? rv32dec_pkg::K_SRAI : rv32dec_pkg::K_SRLI;
            dec.alu_operation = b5 ? rv32dec_pkg::ALU_SRA : rv32dec_pkg::ALU_SRL;
          end
          rv32dec_pkg::F3_OR: begin
            dec.kind          = rv32dec_pkg::K_ORI;
            dec.alu_operation = rv32dec_pkg::ALU_OR;
          end
          default: begin
            dec.kind          = rv32dec_pkg::K_ANDI;
            dec.alu_operation = rv32dec_pkg::ALU_AND;
          end
        endcase
      end
      rv32dec_pkg::OPC_REG: begin
        dec.format        = rv32dec_pkg::FMT_R;
        dec.control_flags = rv32dec_pkg::FLM_REGWRITE;
        if (f7 == rv32dec_pkg::F7_MULDIV) begin
          dec.kind          = rv32dec_pkg::K_MUL + {3'b0, f3};
          dec.alu_operation = rv32dec_pkg::ALU_MUL + {2'b0, f3};
        end else begin
          unique case (f3)
            rv32dec_pkg::F3_ADD: begin
              dec.kind          = b5 ? rv32dec_pkg::K_SUB : rv32dec_pkg::K_ADD;
              dec.alu_operation = b5 ? rv32dec_pkg::ALU_SUB : rv32dec_pkg::ALU_ADD;
            end
            rv32dec_pkg::F3_SLL: begin
              dec.kind          = rv32dec_pkg::K_SLL;
              dec.alu_operation = rv32dec_pkg::ALU_SLL;
            end
            rv32dec_pkg::F3_SLT: begin
              dec.kind          = rv32dec_pkg::K_SLT;
              dec.alu_operation = rv32dec_pkg::ALU_SLT;
            end
            rv32dec_pkg::F3_SLTU: begin
              dec.kind          = rv32dec_pkg::K_SLTU;
              dec.alu_operation = rv32dec_pkg::ALU_SLTU;
            end
            rv32dec_pkg::F3_XOR: begin
              dec.kind          = rv32dec_pkg::K_XOR;
              dec.alu_operation = rv32dec_pkg::ALU_XOR;
            end
            rv32dec_pkg::F3_SR: begin
              dec.kind          = b5 ? rv32dec_pkg::K_SRA : rv32dec_pkg::K_SRL;
              dec.alu_operation = b5 ? rv32dec_pkg::ALU_SRA : rv32dec_pkg::ALU_SRL;
            end
            rv32dec_pkg::F3_OR: begin
              dec.kind          = rv32dec_pkg::K_OR;
              dec.alu_operation = rv32dec_pkg::ALU_OR;
            end
            default: begin
              dec.kind          = rv32dec_pkg::K_AND;
              dec.alu_operation = rv32dec_pkg::ALU_AND;
            end
          endcase
        end
      end
      rv32dec_pkg::OPC_SYSTEM: begin
        dec.format    = rv32dec_pkg::FMT_I;
        dec.immediate = imm_i;
        if (instr[31:20] == rv32dec_pkg::SYS_ECALL) begin
          dec.kind = rv32dec_pkg::K_ECALL;
        end else if (instr[31:20] == rv32dec_pkg::SYS_EBREAK) begin
          dec.kind = rv32dec_pkg::K_EBREAK;
        end
      end
      default: begin
        dec.kind = rv32dec_pkg::K_UNKNOWN;
      end
    endcase
  end

endmodule

// ===== rtl/rv32dec_out_stage.sv =====
// Result register stage: holds one decoded item until the sink takes it.
module rv32dec_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  rv32dec_pkg::res_t up_item,
  output logic              up_ready,
  rv32dec_out_if.source     out_item
);

  logic              valid_r;
  logic              valid_nxt;
  rv32dec_pkg::res_t item_r;

  assign up_ready  = !valid_r || out_item.ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

  assign out_item.valid         = valid_r;
  assign out_item.kind          = item_r.dec.kind;
  assign out_item.format        = item_r.dec.format;
  assign out_item.dest_reg      = item_r.dest_reg;
  assign out_item.src1_reg      = item_r.src1_reg;
  assign out_item.src2_reg      = item_r.src2_reg;
  assign out_item.immediate     = $signed(item_r.dec.immediate);
  assign out_item.alu_operation = item_r.dec.alu_operation;
  assign out_item.control_flags = item_r.dec.control_flags;
  assign out_item.pc_out        = item_r.pc_out;

endmodule

// ===== rtl/rv32im_instruction_decoder_core.sv =====
// Top level: RV32IM instruction decoder, input register, decode, result register.
//
//   channel   dir  handshake        payload
//   in_item   in   valid / ready    instr_word, fetch_pc
//   out_item  out  valid / ready    kind, format, regs, immediate, alu op, flags, pc
//
// Items pass the input then the result register; one item per cycle while out_item is ready.
// Decode is a single pass of logic between the input and result registers.
// Ready propagates back combinationally, so a stalled result only blocks
// intake once both registers hold an item.
// Synchronous active-low reset empties both registers.
`include "rv32im_instruction_decoder_core_defines.svh"

module rv32im_instruction_decoder_core (
  input  logic          clk,
  input  logic          rst_n,
  rv32dec_in_if.sink    in_item,
  rv32dec_out_if.source out_item
);

  logic               s1_valid;
  rv32dec_pkg::word_t s1_instr;
  rv32dec_pkg::word_t s1_pc;
  logic               s2_ready;
  rv32dec_pkg::dec_t  s1_dec;
  rv32dec_pkg::res_t  s1_res;

  rv32dec_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .dn_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_instr (s1_instr),
    .s1_pc    (s1_pc)
  );

  rv32dec_decode u_decode (
    .instr (s1_instr),
    .dec   (s1_dec)
  );

  always_comb begin
    s1_res.dec      = s1_dec;
    s1_res.dest_reg = s1_instr[11:7];
    s1_res.src1_reg = s1_instr[19:15];
    s1_res.src2_reg = s1_instr[24:20];
    s1_res.pc_out   = s1_pc;
  end

  rv32dec_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_item  (s1_res),
    .up_ready (s2_ready),
    .out_item (out_item)
  );

  `RVD_ASSERT(a_pc_follows,
    (s1_valid && s2_ready) |=> (out_item.pc_out == $past(s1_pc)),
    "pc lost between stages")
  `RVD_ASSERT(a_known_has_fmt,
    (out_item.valid && out_item.kind != rv32dec_pkg::K_UNKNOWN) |->
      (out_item.format != rv32dec_pkg::FMT_UNKNOWN),
    "known kind without format")
  `RVD_ASSERT(a_r_no_imm,
    (out_item.valid && out_item.format == rv32dec_pkg::FMT_R) |->
      (out_item.immediate == 0),
    "R format with immediate")
  `RVD_ASSERT(a_branch_fmt,
    (out_item.valid && out_item.control_flags[rv32dec_pkg::FL_BRANCH]) |->
      (out_item.format == rv32dec_pkg::FMT_B),
    "branch flag outside B format")
  `RVD_ASSERT_ALWAYS(a_reset_empty,
    !rst_n |=> (!out_item.valid && !s1_valid),
    "stages not empty after reset")

endmodule

// ===== tb/testbench.sv =====
// Testbench for the RV32IM instruction decoder with a field-by-field result check.
`timescale 1ns / 100ps

module testbench;

  // funct3 codes with no instruction behind them under some opcodes
  localparam logic [2:0] F3_RSV2 = 3'd2;
  localparam logic [2:0] F3_RSV3 = 3'd3;
  localparam logic [2:0] F3_RSV4 = 3'd4;
  localparam logic [6:0] OPC_CUSTOM = 7'h7F;
  localparam int RUN_LIMIT_NS = 2_000_000;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    rv32dec_pkg::word_t instr;
    rv32dec_pkg::word_t addr;
  } fetch_t;

  logic clk = 1'b0;
  logic rst_n;

  rv32dec_in_if  in_ch();
  rv32dec_out_if out_ch();

  rv32im_instruction_decoder_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  fetch_t             fetch_q[$];
  rv32dec_pkg::res_t  pending_decodes[$];
  int                 sent_cnt    = 0;
  int                 results_cnt = 0;
  int                 err_cnt     = 0;
  int                 raw_cnt     = 0;
  int                 hold_left   = 0;
  int                 gap_left    = 0;
  int                 burst_left  = 0;
  bit                 gaps_on     = 1'b0;
  sink_mode_t         sink_mode   = SINK_ALWAYS;
  bit [63:0]          kinds_hit   = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL");
    $finish;
  end

  function automatic rv32dec_pkg::res_t decode_instr(input rv32dec_pkg::word_t w,
                                                     input rv32dec_pkg::word_t pc);
    rv32dec_pkg::res_t  r;
    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic               alt;
    rv32dec_pkg::word_t imm_i, imm_s, imm_b, imm_u, imm_j, shamt;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    alt   = w[30];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {w[31:12], 12'h000};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    shamt = {27'd0, w[24:20]};
    r = '0;
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = w[24:20];
    r.pc_out   = pc;
    case (opc)
      rv32dec_pkg::OPC_LUI: begin
        r.dec.kind          = rv32dec_pkg::K_LUI;
        r.dec.format        = rv32dec_pkg::FMT_U;
        r.dec.immediate     = imm_u;
        r.dec.alu_operation = rv32dec_pkg::ALU_PASS_B;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_AUIPC: begin
        r.dec.kind          = rv32dec_pkg::K_AUIPC;
        r.dec.format        = rv32dec_pkg::FMT_U;
        r.dec.immediate     = imm_u;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_JAL: begin
        r.dec.kind          = rv32dec_pkg::K_JAL;
        r.dec.format        = rv32dec_pkg::FMT_J;
        r.dec.immediate     = imm_j;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_JUMP;
      end
      rv32dec_pkg::OPC_JALR: begin
        r.dec.kind          = rv32dec_pkg::K_JALR;
        r.dec.format        = rv32dec_pkg::FMT_I;
        r.dec.immediate     = imm_i;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_JUMP |
                              rv32dec_pkg::FLM_ALUSRC;
      end
      rv32dec_pkg::OPC_BRANCH: begin
        r.dec.format        = rv32dec_pkg::FMT_B;
        r.dec.immediate     = imm_b;
        r.dec.control_flags = rv32dec_pkg::FLM_BRANCH;
        case (f3)
          rv32dec_pkg::F3_BEQ:  r.dec.kind = rv32dec_pkg::K_BEQ;
          rv32dec_pkg::F3_BNE:  r.dec.kind = rv32dec_pkg::K_BNE;
          rv32dec_pkg::F3_BLT:  r.dec.kind = rv32dec_pkg::K_BLT;
          rv32dec_pkg::F3_BGE:  r.dec.kind = rv32dec_pkg::K_BGE;
          rv32dec_pkg::F3_BLTU: r.dec.kind = rv32dec_pkg::K_BLTU;
          rv32dec_pkg::F3_BGEU: r.dec.kind = rv32dec_pkg::K_BGEU;
          default:              r.dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_LOAD: begin
        r.dec.format        = rv32dec_pkg::FMT_I;
        r.dec.immediate     = imm_i;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_MEMREAD |
                              rv32dec_pkg::FLM_MEMTOREG | rv32dec_pkg::FLM_ALUSRC;
        case (f3)
          rv32dec_pkg::F3_B:  r.dec.kind = rv32dec_pkg::K_LB;
          rv32dec_pkg::F3_H:  r.dec.kind = rv32dec_pkg::K_LH;
          rv32dec_pkg::F3_W:  r.dec.kind = rv32dec_pkg::K_LW;
          rv32dec_pkg::F3_BU: r.dec.kind = rv32dec_pkg::K_LBU;
          rv32dec_pkg::F3_HU: r.dec.kind = rv32dec_pkg::K_LHU;
          default:            r.dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_STORE: begin
        r.dec.format        = rv32dec_pkg::FMT_S;
        r.dec.immediate     = imm_s;
        r.dec.control_flags = rv32dec_pkg::FLM_MEMWRITE | rv32dec_pkg::FLM_ALUSRC;
        case (f3)
          rv32dec_pkg::F3_B: r.dec.kind = rv32dec_pkg::K_SB;
          rv32dec_pkg::F3_H: r.dec.kind = rv32dec_pkg::K_SH;
          rv32dec_pkg::F3_W: r.dec.kind = rv32dec_pkg::K_SW;
          default:           r.dec.kind = rv32dec_pkg::K_UNKNOWN;
        endcase
      end
      rv32dec_pkg::OPC_IMM: begin
        r.dec.format        = rv32dec_pkg::FMT_I;
        r.dec.immediate     = imm_i;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE | rv32dec_pkg::FLM_ALUSRC;
        case (f3)
          rv32dec_pkg::F3_ADD: begin
            r.dec.kind          = rv32dec_pkg::K_ADDI;
            r.dec.alu_operation = rv32dec_pkg::ALU_ADD;
          end
          rv32dec_pkg::F3_SLL: begin
            r.dec.kind          = rv32dec_pkg::K_SLLI;
            r.dec.alu_operation = rv32dec_pkg::ALU_SLL;
            r.dec.immediate     = shamt;
          end
          rv32dec_pkg::F3_SLT: begin
            r.dec.kind          = rv32dec_pkg::K_SLTI;
            r.dec.alu_operation = rv32dec_pkg::ALU_SLT;
          end
          rv32dec_pkg::F3_SLTU: begin
            r.dec.kind          = rv32dec_pkg::K_SLTIU;
            r.dec.alu_operation = rv32dec_pkg::ALU_SLTU;
          end
          rv32dec_pkg::F3_XOR: begin
            r.dec.kind          = rv32dec_pkg::K_XORI;
            r.dec.alu_operation = rv32dec_pkg::ALU_XOR;
          end
          rv32dec_pkg::F3_SR: begin
            r.dec.kind          = alt ? rv32dec_pkg::K_SRAI : rv32dec_pkg::K_SRLI;
            r.dec.alu_operation = alt ? rv32dec_pkg::ALU_SRA : rv32dec_pkg::ALU_SRL;
            r.dec.immediate     = shamt;
          end
          rv32dec_pkg::F3_OR: begin
            r.dec.kind          = rv32dec_pkg::K_ORI;
            r.dec.alu_operation = rv32dec_pkg::ALU_OR;
          end
          default: begin
            r.dec.kind          = rv32dec_pkg::K_ANDI;
            r.dec.alu_operation = rv32dec_pkg::ALU_AND;
          end
        endcase
      end
      rv32dec_pkg::OPC_REG: begin
        r.dec.format        = rv32dec_pkg::FMT_R;
        r.dec.control_flags = rv32dec_pkg::FLM_REGWRITE;
        if (f7 == rv32dec_pkg::F7_MULDIV) begin
          r.dec.kind          = rv32dec_pkg::K_MUL + rv32dec_pkg::kind_t'(f3);
          r.dec.alu_operation = rv32dec_pkg::ALU_MUL + rv32dec_pkg::alu_t'(f3);
        end else begin
          case (f3)
            rv32dec_pkg::F3_ADD: begin
              r.dec.kind          = alt ? rv32dec_pkg::K_SUB : rv32dec_pkg::K_ADD;
              r.dec.alu_operation = alt ? rv32dec_pkg::ALU_SUB : rv32dec_pkg::ALU_ADD;
            end
            rv32dec_pkg::F3_SLL: begin
              r.dec.kind          = rv32dec_pkg::K_SLL;
              r.dec.alu_operation = rv32dec_pkg::ALU_SLL;
            end
            rv32dec_pkg::F3_SLT: begin
              r.dec.kind          = rv32dec_pkg::K_SLT;
              r.dec.alu_operation = rv32dec_pkg::ALU_SLT;
            end
            rv32dec_pkg::F3_SLTU: begin
              r.dec.kind          = rv32dec_pkg::K_SLTU;
              r.dec.alu_operation = rv32dec_pkg::ALU_SLTU;
            end
            rv32dec_pkg::F3_XOR: begin
              r.dec.kind          = rv32dec_pkg::K_XOR;
              r.dec.alu_operation = rv32dec_pkg::ALU_XOR;
            end
            rv32dec_pkg::F3_SR: begin
              r.dec.kind          = alt ? rv32dec_pkg::K_SRA : rv32dec_pkg::K_SRL;
              r.dec.alu_operation = alt ? rv32dec_pkg::ALU_SRA : rv32dec_pkg::ALU_SRL;
            end
            rv32dec_pkg::F3_OR: begin
              r.dec.kind          = rv32dec_pkg::K_OR;
              r.dec.alu_operation = rv32dec_pkg::ALU_OR;
            end
            default: begin
              r.dec.kind          = rv32dec_pkg::K_AND;
              r.dec.alu_operation = rv32dec_pkg::ALU_AND;
            end
          endcase
        end
      end
      rv32dec_pkg::OPC_SYSTEM: begin
        r.dec.format    = rv32dec_pkg::FMT_I;
        r.dec.immediate = imm_i;
        if (w[31:20] == rv32dec_pkg::SYS_ECALL) r.dec.kind = rv32dec_pkg::K_ECALL;
        else if (w[31:20] == rv32dec_pkg::SYS_EBREAK) r.dec.kind = rv32dec_pkg::K_EBREAK;
        else r.dec.kind = rv32dec_pkg::K_UNKNOWN;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic rv32dec_pkg::word_t enc_r(input logic [6:0] f7,
                                               input rv32dec_pkg::reg_idx_t rs2,
                                               input rv32dec_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3,
                                               input rv32dec_pkg::reg_idx_t rd,
                                               input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic rv32dec_pkg::word_t enc_i(input logic [11:0] imm,
                                               input rv32dec_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3,
                                               input rv32dec_pkg::reg_idx_t rd,
                                               input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [6:0] opcode_at(input int idx);
    case (idx)
      0:       return rv32dec_pkg::OPC_LUI;
      1:       return rv32dec_pkg::OPC_AUIPC;
      2:       return rv32dec_pkg::OPC_JAL;
      3:       return rv32dec_pkg::OPC_JALR;
      4:       return rv32dec_pkg::OPC_BRANCH;
      5:       return rv32dec_pkg::OPC_LOAD;
      6:       return rv32dec_pkg::OPC_STORE;
      7:       return rv32dec_pkg::OPC_IMM;
      8:       return rv32dec_pkg::OPC_REG;
      default: return rv32dec_pkg::OPC_SYSTEM;
    endcase
  endfunction

  function automatic rv32dec_pkg::word_t rand_pc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly valid encodings with random fields; some raw words as noise
  function automatic rv32dec_pkg::word_t rand_instr();
    rv32dec_pkg::word_t w;
    logic [6:0]         opc;
    w = $urandom();
    if ($urandom_range(0, 99) < 12) begin
      raw_cnt++;
      return w;
    end
    opc    = opcode_at($urandom_range(0, 9));
    w[6:0] = opc;
    case ($urandom_range(0, 3))
      0:       w[31:25] = 7'h00;
      1:       w[31:25] = 7'h20;
      2:       w[31:25] = rv32dec_pkg::F7_MULDIV;
      default: ;
    endcase
    if (opc == rv32dec_pkg::OPC_SYSTEM && $urandom_range(0, 2) != 0)
      w[31:20] = $urandom_range(0, 1) ? rv32dec_pkg::SYS_EBREAK : rv32dec_pkg::SYS_ECALL;
    return w;
  endfunction

  task automatic send_instr(input rv32dec_pkg::word_t instr, input rv32dec_pkg::word_t addr);
    while (fetch_q.size() >= 2) @(posedge clk);
    fetch_q.push_back({instr, addr});
    sent_cnt++;
  endtask

  task automatic wait_drained();
    wait (results_cnt >= sent_cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // sender: bursts of items, separated by random gaps when gaps_on is set
  initial begin : fetch_driver
    fetch_t nxt;
    in_ch.valid      = 1'b0;
    in_ch.instr_word = '0;
    in_ch.fetch_pc   = '0;
    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        pending_decodes.push_back(decode_instr(in_ch.instr_word, in_ch.fetch_pc));
        kinds_hit[pending_decodes[$].dec.kind] = 1'b1;
      end
      if (!rst_n) begin
        in_ch.valid <= 1'b0;
      end else if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (fetch_q.size() > 0) begin
          nxt = fetch_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.instr_word <= nxt.instr;
          in_ch.fetch_pc   <= nxt.addr;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            if (gaps_on) gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: hold-off counter first, then the selected stall pattern
  initial begin : result_sink
    int pat_cnt;
    pat_cnt      = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: out_ch.ready <= 1'b1;
          SINK_RANDOM: out_ch.ready <= ($urandom_range(0, 99) < 65);
          default:     out_ch.ready <= (pat_cnt % 5 != 0) && (pat_cnt % 13 < 9);
        endcase
      end
    end
  end

  initial begin : result_checker
    rv32dec_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_cnt++;
        if (pending_decodes.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual kind %0d pc %h",
                   $time, out_ch.kind, out_ch.pc_out);
        end else begin
          want = pending_decodes.pop_front();
          check_field("kind", 32'(want.dec.kind), 32'(out_ch.kind));
          check_field("format", 32'(want.dec.format), 32'(out_ch.format));
          check_field("dest_reg", 32'(want.dest_reg), 32'(out_ch.dest_reg));
          check_field("src1_reg", 32'(want.src1_reg), 32'(out_ch.src1_reg));
          check_field("src2_reg", 32'(want.src2_reg), 32'(out_ch.src2_reg));
          check_field("immediate", want.dec.immediate, 32'(out_ch.immediate));
          check_field("alu_operation", 32'(want.dec.alu_operation),
                      32'(out_ch.alu_operation));
          check_field("control_flags", 32'(want.dec.control_flags),
                      32'(out_ch.control_flags));
          check_field("pc_out", want.pc_out, out_ch.pc_out);
        end
      end
    end
  end

  task automatic test_directed();
    gaps_on   = 1'b0;
    sink_mode = SINK_ALWAYS;
    send_instr({20'hFFFFF, 5'd31, rv32dec_pkg::OPC_LUI}, '0);
    send_instr({20'h80000, 5'd0, rv32dec_pkg::OPC_AUIPC}, '1);
    send_instr({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, rv32dec_pkg::OPC_JAL}, rand_pc());
    send_instr({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, rv32dec_pkg::OPC_JAL}, rand_pc());
    send_instr(enc_i(12'h800, 5'd31, rv32dec_pkg::F3_AND, 5'd5, rv32dec_pkg::OPC_JALR),
               rand_pc());
    send_instr({1'b0, 6'h3F, 5'd31, 5'd31, rv32dec_pkg::F3_BEQ, 4'hF, 1'b1,
                rv32dec_pkg::OPC_BRANCH}, rand_pc());
    send_instr({1'b1, 6'h00, 5'd0, 5'd0, rv32dec_pkg::F3_BGEU, 4'h0, 1'b0,
                rv32dec_pkg::OPC_BRANCH}, rand_pc());
    send_instr({1'b1, 6'h2A, 5'd3, 5'd4, F3_RSV2, 4'h5, 1'b1, rv32dec_pkg::OPC_BRANCH},
               rand_pc());
    send_instr(enc_i(12'h7FF, 5'd2, rv32dec_pkg::F3_W, 5'd3, rv32dec_pkg::OPC_LOAD),
               rand_pc());
    send_instr(enc_i(12'hFFF, 5'd0, rv32dec_pkg::F3_HU, 5'd31, rv32dec_pkg::OPC_LOAD),
               rand_pc());
    send_instr(enc_i(12'h123, 5'd7, F3_RSV3, 5'd8, rv32dec_pkg::OPC_LOAD), rand_pc());
    send_instr({7'h7F, 5'd9, 5'd10, rv32dec_pkg::F3_B, 5'h1F, rv32dec_pkg::OPC_STORE},
               rand_pc());
    send_instr({7'h40, 5'd1, 5'd2, rv32dec_pkg::F3_W, 5'h00, rv32dec_pkg::OPC_STORE},
               rand_pc());
    send_instr({7'h00, 5'd1, 5'd2, F3_RSV4, 5'h01, rv32dec_pkg::OPC_STORE}, rand_pc());
    send_instr(enc_i(12'h800, 5'd1, rv32dec_pkg::F3_ADD, 5'd1, rv32dec_pkg::OPC_IMM),
               rand_pc());
    send_instr(enc_i(12'h7FF, 5'd1, rv32dec_pkg::F3_SLTU, 5'd1, rv32dec_pkg::OPC_IMM),
               rand_pc());
    // shift immediates: funct7 other than bit 5 is don't-care
    send_instr(enc_r(7'h7F, 5'd31, 5'd1, rv32dec_pkg::F3_SLL, 5'd2, rv32dec_pkg::OPC_IMM),
               rand_pc());
    send_instr(enc_r(7'h5F, 5'd17, 5'd3, rv32dec_pkg::F3_SR, 5'd4, rv32dec_pkg::OPC_IMM),
               rand_pc());
    send_instr(enc_r(7'h20, 5'd0, 5'd5, rv32dec_pkg::F3_SR, 5'd6, rv32dec_pkg::OPC_IMM),
               rand_pc());
    send_instr(enc_r(7'h5F, 5'd7, 5'd8, rv32dec_pkg::F3_ADD, 5'd9, rv32dec_pkg::OPC_REG),
               rand_pc());
    send_instr(enc_r(7'h20, 5'd10, 5'd11, rv32dec_pkg::F3_ADD, 5'd12,
                     rv32dec_pkg::OPC_REG), rand_pc());
    send_instr(enc_r(7'h20, 5'd13, 5'd14, rv32dec_pkg::F3_SLL, 5'd15,
                     rv32dec_pkg::OPC_REG), rand_pc());
    send_instr(enc_r(7'h7F, 5'd16, 5'd17, rv32dec_pkg::F3_SR, 5'd18,
                     rv32dec_pkg::OPC_REG), rand_pc());
    send_instr(enc_r(rv32dec_pkg::F7_MULDIV, 5'd19, 5'd20, rv32dec_pkg::F3_ADD, 5'd21,
                     rv32dec_pkg::OPC_REG), rand_pc());
    send_instr(enc_r(rv32dec_pkg::F7_MULDIV, 5'd31, 5'd31, rv32dec_pkg::F3_AND, 5'd31,
                     rv32dec_pkg::OPC_REG), rand_pc());
    send_instr(enc_i(rv32dec_pkg::SYS_ECALL, 5'd31, rv32dec_pkg::F3_AND, 5'd31,
                     rv32dec_pkg::OPC_SYSTEM), rand_pc());
    send_instr(enc_i(rv32dec_pkg::SYS_EBREAK, 5'd0, rv32dec_pkg::F3_ADD, 5'd0,
                     rv32dec_pkg::OPC_SYSTEM), rand_pc());
    send_instr(enc_i(12'hFFF, 5'd1, rv32dec_pkg::F3_ADD, 5'd1, rv32dec_pkg::OPC_SYSTEM),
               rand_pc());
    send_instr({25'h1ABCDEF, OPC_CUSTOM}, rand_pc());
    send_instr('0, '0);
    send_instr('1, '1);
    wait_drained();
  endtask

  task automatic test_opcode_sweep();
    rv32dec_pkg::word_t w;
    gaps_on   = 1'b1;
    sink_mode = SINK_PATTERN;
    for (int op = 0; op < 10; op++) begin
      for (int f3 = 0; f3 < 8; f3++) begin
        w          = rand_instr();
        w[6:0]     = opcode_at(op);
        w[14:12]   = 3'(f3);
        send_instr(w, rand_pc());
      end
    end
    wait_drained();
  endtask

  task automatic test_full_rate();
    gaps_on   = 1'b0;
    sink_mode = SINK_ALWAYS;
    for (int i = 0; i < 200; i++) send_instr(rand_instr(), rand_pc());
    wait_drained();
  endtask

  // sink holds off long enough for both stages to fill and stall intake
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    sink_mode = SINK_ALWAYS;
    hold_left = 80;
    for (int i = 0; i < 100; i++) send_instr(rand_instr(), rand_pc());
    wait_drained();
  endtask

  task automatic test_random_stream(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        sink_mode = sink_mode_t'($urandom_range(0, 2));
      end
      send_instr(rand_instr(), rand_pc());
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_opcode_sweep();
    test_full_rate();
    test_backpressure();
    test_random_stream(900);
    repeat (10) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d decodes never returned", $time, pending_decodes.size());
    end
    $display("Sent %0d instructions (%0d raw words), %0d of 48 kinds decoded",
             sent_cnt, raw_cnt, $countones(kinds_hit));
    $display("Checked %0d results, %0d field mismatches", results_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
